// ===== rtl/core/lcs_pkg.sv =====
// shared types and constants for the lcg cycle length search
package lcs_pkg;

  localparam int WordBitsDefault = 12;

  // configuration register indexes
  localparam int CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegSeedFirst = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegSeedEnd   = 1'b1;

  // reset value of the seed_end register
  localparam int SeedEndReset = 1;

  // running best control from the sequencer
  typedef struct packed {
    logic clear;
    logic commit;
  } best_ctl_t;

endpackage

// ===== rtl/core/lcs_mulmod.sv =====
// shared step unit: (m * n + c) mod p, one remainder bit per cycle
module lcs_mulmod #(
  parameter int WordBits = lcs_pkg::WordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] mult_i,
  input  logic [WordBits-1:0] val_i,
  input  logic [WordBits-1:0] inc_i,
  input  logic [WordBits-1:0] mod_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [WordBits-1:0] rem_o
);

  localparam int ProdBits = 2 * WordBits;
  localparam int CntBits  = $clog2(ProdBits);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [ProdBits-1:0] prod_q, prod_d;
  logic [WordBits-1:0] rem_q, rem_d;
  logic [WordBits-1:0] mod_q, mod_d;
  logic [WordBits:0]   trial;
  logic [WordBits:0]   diff;

  assign trial = {rem_q, prod_q[ProdBits-1]};
  assign diff  = trial - {1'b0, mod_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    mod_d  = mod_q;
    if (start_i) begin
      prod_d = ProdBits'(mult_i) * ProdBits'(val_i) + ProdBits'(inc_i);
      rem_d  = '0;
      mod_d  = mod_i;
      cnt_d  = CntBits'(ProdBits - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring remainder step
      if (trial >= {1'b0, mod_q}) begin
        rem_d = diff[WordBits-1:0];
      end else begin
        rem_d = trial[WordBits-1:0];
      end
      prod_d = {prod_q[ProdBits-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    mod_q  <= mod_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/lcs_best.sv =====
// running best generator over all items since the last clear
module lcs_best #(
  parameter int WordBits = lcs_pkg::WordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcs_pkg::best_ctl_t  ctl_i,
  input  logic                found_i,
  input  logic [WordBits-1:0] mult_i,
  input  logic [WordBits-1:0] inc_i,
  input  logic [WordBits-1:0] mod_i,
  input  logic [WordBits-1:0] seed_i,
  input  logic [WordBits-1:0] len_i,
  output logic                valid_o,
  output logic [WordBits-1:0] mult_o,
  output logic [WordBits-1:0] inc_o,
  output logic [WordBits-1:0] mod_o,
  output logic [WordBits-1:0] seed_o,
  output logic [WordBits-1:0] len_o
);

  logic                valid_q, valid_d;
  logic [WordBits-1:0] mult_q, mult_d;
  logic [WordBits-1:0] inc_q, inc_d;
  logic [WordBits-1:0] mod_q, mod_d;
  logic [WordBits-1:0] seed_q, seed_d;
  logic [WordBits-1:0] len_q, len_d;

  always_comb begin
    valid_d = valid_q;
    mult_d  = mult_q;
    inc_d   = inc_q;
    mod_d   = mod_q;
    seed_d  = seed_q;
    len_d   = len_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
      mult_d  = '0;
      inc_d   = '0;
      mod_d   = '0;
      seed_d  = '0;
      len_d   = '0;
    end else if (ctl_i.commit && found_i && (!valid_q || len_i > len_q)) begin
      valid_d = 1'b1;
      mult_d  = mult_i;
      inc_d   = inc_i;
      mod_d   = mod_i;
      seed_d  = seed_i;
      len_d   = len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mult_q  <= '0;
      inc_q   <= '0;
      mod_q   <= '0;
      seed_q  <= '0;
      len_q   <= '0;
    end else begin
      valid_q <= valid_d;
      mult_q  <= mult_d;
      inc_q   <= inc_d;
      mod_q   <= mod_d;
      seed_q  <= seed_d;
      len_q   <= len_d;
    end
  end

  assign valid_o = valid_q;
  assign mult_o  = mult_q;
  assign inc_o   = inc_q;
  assign mod_o   = mod_q;
  assign seed_o  = seed_q;
  assign len_o   = len_q;

endmodule

// ===== rtl/core/lcg_cycle_length_search.sv =====
// top level: lcg cycle length search over a configured seed range
//
// channel   direction  words
// s_axis    in         one generator: multiplier, increment, modulus; restart in tuser
// m_axis    out        one result per generator: this item's best and the running best
// cfg       in         register index and data, taken at any time, used while idle
//
// every generator step runs through one shared multiply and bit-serial remainder unit,
// up to p steps per seed, one seed after another
// s_axis_tready_o is low from acceptance until the result is loaded into the output register
// a result waiting on m_axis does not block the next word; a second result waits for it
// reset clears the running best and sets seed_first to 0 and seed_end to 1
module lcg_cycle_length_search #(
  parameter int WordBits = lcs_pkg::WordBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // multiplier, increment, modulus
  input  logic [((3*WordBits+7)/8)*8-1:0]  s_axis_tdata_i,
  // restart
  input  logic [0:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // cycle_found, cycle_seed, cycle_length, best_found, best_multiplier,
  // best_increment, best_modulus, best_seed, best_length
  output logic [((7*WordBits+9)/8)*8-1:0]  m_axis_tdata_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lcs_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [WordBits:0]                cfg_data_i
);

  localparam int W       = WordBits;
  localparam int OutBits = ((7*WordBits+9)/8)*8;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSeed = 3'd1;
  localparam logic [2:0] StStep = 3'd2;
  localparam logic [2:0] StWait = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StPush = 3'd5;

  logic [2:0]   state_q, state_d;
  logic [W-1:0] seed_first_q, seed_first_d;
  logic [W:0]   seed_end_q, seed_end_d;

  logic [W-1:0] m_q, m_d, c_q, c_d, p_q, p_d, stop_q, stop_d;
  logic [W-1:0] s_q, s_d, n_q, n_d, len_q, len_d;
  logic         found_q, found_d;
  logic [W-1:0] fseed_q, fseed_d, flen_q, flen_d;

  logic         out_valid_q, out_valid_d;
  logic [OutBits-1:0] out_data_q, out_data_d;

  logic         in_fire;
  logic         mm_start, mm_busy, mm_done;
  logic [W-1:0] mm_rem;
  logic [W-1:0] len_next;
  logic [W-1:0] in_m, in_c, in_p;

  lcs_pkg::best_ctl_t best_ctl;
  logic         best_valid;
  logic [W-1:0] best_mult, best_inc, best_mod, best_seed, best_len;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign cfg_ready_o     = 1'b1;

  assign in_m     = s_axis_tdata_i[W-1:0];
  assign in_c     = s_axis_tdata_i[2*W-1:W];
  assign in_p     = s_axis_tdata_i[3*W-1:2*W];
  assign len_next = len_q + 1'b1;

  always_comb begin
    seed_first_d = seed_first_q;
    seed_end_d   = seed_end_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lcs_pkg::RegSeedFirst: seed_first_d = cfg_data_i[W-1:0];
        lcs_pkg::RegSeedEnd:   seed_end_d   = cfg_data_i;
        default:               seed_end_d   = seed_end_q;
      endcase
    end
  end

  always_comb begin
    state_d         = state_q;
    m_d             = m_q;
    c_d             = c_q;
    p_d             = p_q;
    stop_d          = stop_q;
    s_d             = s_q;
    n_d             = n_q;
    len_d           = len_q;
    found_d         = found_q;
    fseed_d         = fseed_q;
    flen_d          = flen_q;
    mm_start        = 1'b0;
    best_ctl.clear  = 1'b0;
    best_ctl.commit = 1'b0;
    out_valid_d     = out_valid_q && !m_axis_tready_i;
    out_data_d      = out_data_q;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          m_d            = in_m;
          c_d            = in_c;
          p_d            = in_p;
          // seeds at or above the modulus never come back
          stop_d         = ({1'b0, in_p} < seed_end_q) ? in_p : seed_end_q[W-1:0];
          s_d            = seed_first_q;
          found_d        = 1'b0;
          fseed_d        = '0;
          flen_d         = '0;
          best_ctl.clear = s_axis_tuser_i[0];
          state_d        = StSeed;
        end
      end
      StSeed: begin
        if (s_q < stop_q) begin
          n_d     = s_q;
          len_d   = '0;
          state_d = StStep;
        end else begin
          state_d = StFin;
        end
      end
      StStep: begin
        mm_start = 1'b1;
        state_d  = StWait;
      end
      StWait: begin
        if (mm_done) begin
          if (mm_rem == s_q) begin
            if (len_next != p_q && (!found_q || len_next >= flen_q)) begin
              found_d = 1'b1;
              fseed_d = s_q;
              flen_d  = len_next;
            end
            s_d     = s_q + 1'b1;
            state_d = StSeed;
          end else if (len_next == p_q) begin
            s_d     = s_q + 1'b1;
            state_d = StSeed;
          end else begin
            n_d     = mm_rem;
            len_d   = len_next;
            state_d = StStep;
          end
        end
      end
      StFin: begin
        best_ctl.commit = 1'b1;
        state_d         = StPush;
      end
      StPush: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = OutBits'({best_len, best_seed, best_mod, best_inc, best_mult,
                                  best_valid, flen_q, fseed_q, found_q});
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      seed_first_q <= '0;
      seed_end_q   <= (W+1)'(lcs_pkg::SeedEndReset);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      seed_first_q <= seed_first_d;
      seed_end_q   <= seed_end_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q        <= m_d;
    c_q        <= c_d;
    p_q        <= p_d;
    stop_q     <= stop_d;
    s_q        <= s_d;
    n_q        <= n_d;
    len_q      <= len_d;
    found_q    <= found_d;
    fseed_q    <= fseed_d;
    flen_q     <= flen_d;
    out_data_q <= out_data_d;
  end

  lcs_mulmod #(
    .WordBits(W)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .mult_i  (m_q),
    .val_i   (n_q),
    .inc_i   (c_q),
    .mod_i   (p_q),
    .busy_o  (mm_busy),
    .done_o  (mm_done),
    .rem_o   (mm_rem)
  );

  lcs_best #(
    .WordBits(W)
  ) u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (best_ctl),
    .found_i (found_q),
    .mult_i  (m_q),
    .inc_i   (c_q),
    .mod_i   (p_q),
    .seed_i  (fseed_q),
    .len_i   (flen_q),
    .valid_o (best_valid),
    .mult_o  (best_mult),
    .inc_o   (best_inc),
    .mod_o   (best_mod),
    .seed_o  (best_seed),
    .len_o   (best_len)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_unit_idle_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (!mm_busy && !mm_done))
    else $error("step unit active while sequencer idle");

  a_start_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_start |-> !mm_busy)
    else $error("step started while unit busy");

  a_found_len_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && state_q != StIdle) |-> (flen_q != '0 && flen_q < p_q))
    else $error("qualifying length out of range");

  a_best_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_valid |-> (best_len != '0))
    else $error("running best holds zero length");

endmodule
